### sv/quantile_admission_check_unit_assert.svh
// Assertion macros for the quantile admission check unit.
// Needs clk and rst in the scope of the including module.
`ifndef QUANTILE_ADMISSION_CHECK_UNIT_ASSERT_SVH
`define QUANTILE_ADMISSION_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qac: check failed");

// Next-cycle implication, checked outside reset.
`define QAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qac: check failed");

`endif

### sv/qac_pkg.sv
// Shared types and constants for the quantile admission check unit.
// No dependencies.
package qac_pkg;

  localparam int WinMax = 64;
  localparam int WinAw  = 6;
  localparam int RankW  = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_SCAN, ST_UPD, ST_CNT,
    ST_MUL1, ST_MUL2, ST_CMP, ST_FIN
  } qac_state_t;

  typedef enum logic [1:0] {
    V_ADMIT = 2'd0,
    V_FULL  = 2'd1,
    V_OVER  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    CFG_DEFLECT  = 3'd0,
    CFG_DIVISOR  = 3'd1,
    CFG_WINDOW   = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_KFRAC    = 3'd4,
    CFG_CAPACITY = 3'd5,
    CFG_CAPBITS  = 3'd6
  } cfg_index_t;

endpackage

### sv/quantile_admission_check_unit.sv
// Quantile admission check: rank forming, window scan and threshold test.
// Depends on qac_pkg and quantile_admission_check_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one packet item; in_stall is
//   high while an item is being worked on. Output channel (out_valid/
//   out_stall) returns verdict, rank and below_count, one result per item.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; write them only while the block is idle.
//   The rank path is decided first; each retransmission division then runs
//   bit-serially over all 32 rank bits, followed by the decide step again;
//   then on the quantile path the window memory is scanned (each read is
//   compared as it returns), followed by one update step, a wrap of the
//   sample counter, two multiply stages, one compare and the output state.
//   One item is processed at a time; the next is taken as soon as the
//   previous result sits in the output register.
//   Reset clears configuration to defaults, empties the window and the
//   sample counter; window memory contents need no clearing.
//   When the receiver stalls, the result holds in the output register and
//   a following item finishes its work then waits until that slot frees.
module quantile_admission_check_unit
  import qac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seq_number,
  input  logic [3:0]  retrans_count,
  input  logic        is_data,
  input  logic [23:0] pkt_len,
  input  logic [23:0] queue_fill,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [31:0] rank,
  output logic [6:0]  below_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // configuration
  logic        de_r;
  logic [7:0]  div_r;
  logic [6:0]  wsize_r;
  logic [9:0]  per_r;
  logic [16:0] kfrac_r;
  logic [23:0] cap_r;
  logic        capbits_r;

  qac_state_t state, state_next;

  // item
  logic [RankW-1:0] rank_r;
  logic [3:0]       rc_r;
  logic [3:0]       pass_r;
  logic             data_r;
  logic             full_r;
  logic [23:0]      q_r;
  logic [7:0]       rem_r;
  logic [4:0]       bitcnt;

  // window
  logic [RankW-1:0] mem [WinMax];
  logic [RankW-1:0] rd_data;
  logic [WinAw-1:0] rd_addr;
  logic [WinAw-1:0] head;
  logic [WinAw:0]   fill;
  logic [WinAw:0]   iss;
  logic             rd_pend;
  logic [6:0]       below;
  logic [9:0]       ctr;
  logic [10:0]      ctr_v;
  logic             we;
  logic [WinAw-1:0] wr_addr;

  logic [30:0]      qw;
  logic [22:0]      kc;
  logic [46:0]      rhs;
  logic [1:0]       res_verdict;

  // effective settings
  logic [6:0]  w_eff;
  logic [9:0]  per_eff;
  logic [16:0] k_eff;
  logic [6:0]  cnt_sat;
  logic        div_on;
  logic        accept;
  logic        out_load;
  logic [8:0]  div_t;
  logic        div_ge;
  logic [WinAw:0]   f_keep;
  logic [WinAw-1:0] head_new;

  always_comb begin
    w_eff   = (wsize_r == 7'd0) ? 7'd1 :
              (wsize_r > 7'(WinMax)) ? 7'(WinMax) : wsize_r;
    per_eff = (per_r == 10'd0) ? 10'd1 : per_r;
    k_eff   = (kfrac_r > 17'h10000) ? 17'h10000 : kfrac_r;
    cnt_sat = (below > w_eff) ? w_eff : below;
    div_on  = data_r && de_r && (div_r != 8'd0);
    div_t   = {rem_r, rank_r[RankW-1]};
    div_ge  = div_t >= {1'b0, div_r};
    if (fill >= w_eff) begin
      head_new = head + WinAw'(fill - w_eff + 7'd1);
      f_keep   = w_eff - 7'd1;
    end else begin
      head_new = head;
      f_keep   = fill;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);
  assign rd_addr   = head + iss[WinAw-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      de_r      <= 1'b0;
      div_r     <= 8'd0;
      wsize_r   <= 7'd64;
      per_r     <= 10'd1;
      kfrac_r   <= 17'd0;
      cap_r     <= 24'd64;
      capbits_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEFLECT:  de_r      <= cfg_data[0];
        CFG_DIVISOR:  div_r     <= cfg_data[7:0];
        CFG_WINDOW:   wsize_r   <= cfg_data[6:0];
        CFG_PERIOD:   per_r     <= cfg_data[9:0];
        CFG_KFRAC:    kfrac_r   <= cfg_data[16:0];
        CFG_CAPACITY: cap_r     <= cfg_data[23:0];
        CFG_CAPBITS:  capbits_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_PREP;
      ST_PREP: begin
        if (div_on && pass_r != rc_r) state_next = ST_DIV;
        else if (full_r || !de_r)     state_next = ST_FIN;
        else                          state_next = ST_SCAN;
      end
      ST_DIV:  if (bitcnt == 5'd31) state_next = ST_PREP;
      ST_SCAN: if (iss == fill && !rd_pend) state_next = ST_UPD;
      ST_UPD:  state_next = ST_CNT;
      ST_CNT:  if (ctr_v < {1'b0, per_eff}) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_CMP;
      ST_CMP:  state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // window memory
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= rank_r;
    rd_data <= mem[rd_addr];
  end

  assign we      = (state == ST_UPD) && (ctr == 10'd0);
  assign wr_addr = head_new + f_keep[WinAw-1:0];

  // item datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      head    <= '0;
      ctr     <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rank_r  <= is_data ? seq_number : '0;
            rc_r    <= retrans_count;
            data_r  <= is_data;
            q_r     <= queue_fill;
            pass_r  <= '0;
            below   <= '0;
            iss     <= '0;
            rd_pend <= 1'b0;
            full_r  <= capbits_r
                       ? ({1'b0, queue_fill} + {1'b0, pkt_len}) >= {1'b0, cap_r}
                       : (queue_fill >= cap_r);
          end
        end
        ST_PREP: begin
          if (div_on && pass_r != rc_r) begin
            rem_r  <= '0;
            bitcnt <= '0;
          end else begin
            if (div_on && rank_r == '0) rank_r <= RankW'(1);
            res_verdict <= full_r ? V_FULL : V_ADMIT;
          end
        end
        ST_DIV: begin
          rem_r  <= div_ge ? 8'(div_t - {1'b0, div_r}) : div_t[7:0];
          rank_r <= {rank_r[RankW-2:0], div_ge};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd31) pass_r <= pass_r + 4'd1;
        end
        ST_SCAN: begin
          // one read issued a cycle, compared when it returns
          rd_pend <= (iss != fill);
          if (iss != fill) iss <= iss + 7'd1;
          if (rd_pend && rd_data < rank_r) below <= below + 7'd1;
        end
        ST_UPD: begin
          if (ctr == 10'd0) begin
            head <= head_new;
            fill <= f_keep + 7'd1;
          end
          ctr_v <= {1'b0, ctr} + 11'd1;
        end
        ST_CNT: begin
          // wrap by repeated subtraction; one step unless the period shrank
          if (ctr_v >= {1'b0, per_eff}) ctr_v <= ctr_v - {1'b0, per_eff};
          else                          ctr   <= ctr_v[9:0];
        end
        ST_MUL1: begin
          qw <= q_r * w_eff;
          kc <= 23'(17'h10000 - k_eff) * 23'(cnt_sat);
        end
        ST_MUL2: rhs <= cap_r * (23'({w_eff, 16'h0}) - kc);
        ST_CMP:  res_verdict <= ({qw, 16'h0} > rhs) ? V_OVER : V_ADMIT;
        ST_FIN: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid   <= 1'b1;
      verdict     <= res_verdict;
      rank        <= rank_r;
      below_count <= below;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`include "quantile_admission_check_unit_assert.svh"

  `QAC_ASSERT_NOW(a_fill_bound, 1'b1, fill <= 7'(WinMax))
  `QAC_ASSERT_NOW(a_full_no_count, out_load && res_verdict == V_FULL, below == 7'd0)
  `QAC_ASSERT_NEXT(a_push_fills, state == ST_UPD && ctr == 10'd0, fill != 7'd0)

endmodule

### sim/quantile_admission_check_unit_tb.sv
// Self-checking bench for the quantile admission check unit: random and directed
// packet items against an in-bench predictor of rank, window scan and threshold.
// Depends on qac_pkg and the quantile_admission_check_unit RTL.
module quantile_admission_check_unit_tb;
  import qac_pkg::*;

  typedef struct {
    logic [31:0] seq;
    logic [3:0]  rc;
    logic        data;
    logic [23:0] plen;
    logic [23:0] fill;
  } packet_t;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] rank;
    logic [6:0]  below;
  } decision_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] seq_number = '0;
  logic [3:0]  retrans_count = '0;
  logic        is_data = 1'b0;
  logic [23:0] pkt_len = '0;
  logic [23:0] queue_fill = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic [31:0] rank;
  logic [6:0]  below_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_DEFLECT;
  logic [23:0] cfg_data = '0;

  // predictor copy of the registers and window
  logic        m_deflect;
  logic [7:0]  m_divisor;
  logic [6:0]  m_window;
  logic [9:0]  m_period;
  logic [16:0] m_kfrac;
  logic [23:0] m_capacity;
  logic        m_capbits;
  logic [31:0] win_ranks [WinMax];
  int          win_fill;
  int          sample_cnt;

  packet_t     pending_packets[$];
  decision_t   expected_decisions[$];
  packet_t     cur_packet;
  int          send_gap;
  int          stall_len;
  bit          gaps_on;
  int          n_errors;

  quantile_admission_check_unit dut (.*);

  always #1 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic decision_t predict_admission(packet_t p);
    decision_t d;
    logic [31:0] r;
    longint unsigned w, per, k, cnt, lhs, rhs;
    int below, drop;
    bit full;
    r = p.data ? p.seq : 32'd0;
    if (p.data && m_deflect && m_divisor != 0) begin
      for (int i = 0; i < p.rc; i++) r = r / m_divisor;
      if (r == 0) r = 32'd1;
    end
    full = m_capbits ? ({1'b0, p.fill} + {1'b0, p.plen} >= {1'b0, m_capacity})
                     : (p.fill >= m_capacity);
    below = 0;
    d.verdict = V_ADMIT;
    if (full) begin
      d.verdict = V_FULL;
    end else if (m_deflect) begin
      w = (m_window == 0) ? 1 : (m_window > WinMax ? WinMax : m_window);
      per = (m_period == 0) ? 1 : m_period;
      k = (m_kfrac > 65536) ? 65536 : m_kfrac;
      for (int i = 0; i < win_fill; i++)
        if (win_ranks[i] < r) below++;
      if (sample_cnt == 0) begin
        // evict the oldest until w-1 are left, then append
        if (win_fill >= w) begin
          drop = win_fill - int'(w) + 1;
          for (int i = 0; i < win_fill - drop; i++) win_ranks[i] = win_ranks[i + drop];
          win_fill -= drop;
        end
        if (win_fill < WinMax) begin
          win_ranks[win_fill] = r;
          win_fill++;
        end
      end
      sample_cnt = (sample_cnt + 1) % per;
      cnt = (below > w) ? w : below;
      lhs = longint'(p.fill) * w * 65536;
      rhs = longint'(m_capacity) * (w * 65536 - (65536 - k) * cnt);
      if (lhs > rhs) d.verdict = V_OVER;
    end
    d.rank = r;
    d.below = below[6:0];
    return d;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_decisions.insert(expected_decisions.size(), predict_admission(cur_packet));
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_packets.size() > 0) begin
          cur_packet = pending_packets[0];
          pending_packets.delete(0);
          seq_number <= cur_packet.seq;
          retrans_count <= cur_packet.rc;
          is_data <= cur_packet.data;
          pkt_len <= cur_packet.plen;
          queue_fill <= cur_packet.fill;
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and stall generator
  always @(posedge clk) begin
    decision_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_len <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_decisions.size() == 0) begin
          $error("unexpected result: verdict %0d rank %0h", verdict, rank);
          n_errors++;
        end else begin
          e = expected_decisions[0];
          expected_decisions.delete(0);
          if (verdict !== e.verdict) begin
            $error("verdict: expected %0d, got %0d", e.verdict, verdict);
            n_errors++;
          end
          if (rank !== e.rank) begin
            $error("rank: expected %0h, got %0h", e.rank, rank);
            n_errors++;
          end
          if (below_count !== e.below) begin
            $error("below_count: expected %0d, got %0d", e.below, below_count);
            n_errors++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        out_stall <= 1'b1;
      end else begin
        stall_len <= rand_gap();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [23:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEFLECT:  m_deflect = value[0];
      CFG_DIVISOR:  m_divisor = value[7:0];
      CFG_WINDOW:   m_window = value[6:0];
      CFG_PERIOD:   m_period = value[9:0];
      CFG_KFRAC:    m_kfrac = value[16:0];
      CFG_CAPACITY: m_capacity = value;
      CFG_CAPBITS:  m_capbits = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_packet(logic [31:0] s, logic [3:0] c, logic d, logic [23:0] l,
                              logic [23:0] f);
    packet_t p;
    p.seq = s;
    p.rc = c;
    p.data = d;
    p.plen = l;
    p.fill = f;
    pending_packets.insert(pending_packets.size(), p);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    do @(posedge clk);
    while (pending_packets.size() != 0 || in_valid || expected_decisions.size() != 0);
  endtask

  function automatic logic [23:0] pick(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                                       logic [23:0] rnd);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return rnd;
    endcase
  endfunction

  initial begin
    logic [31:0] s;
    logic [23:0] f;
    m_deflect = 1'b0; m_divisor = 8'd0; m_window = 7'd64; m_period = 10'd1;
    m_kfrac = 17'd0; m_capacity = 24'd64; m_capbits = 1'b0;
    win_fill = 0; sample_cnt = 0; n_errors = 0; gaps_on = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults: deflection off, packet-mode capacity 64
    queue_packet(32'hFFFF_FFFF, 4'hF, 1'b1, 24'hFF_FFFF, 24'd0);
    queue_packet(32'd0, 4'd0, 1'b0, 24'd0, 24'd63);
    queue_packet(32'd5, 4'd3, 1'b1, 24'd0, 24'd64);
    queue_packet(32'h8000_0000, 4'd1, 1'b1, 24'd10, 24'hFF_FFFF);
    drain();

    write_reg(CFG_DEFLECT, 24'd1);
    write_reg(CFG_DIVISOR, 24'd2);
    write_reg(CFG_WINDOW, 24'd4);
    write_reg(CFG_PERIOD, 24'd1);
    write_reg(CFG_KFRAC, 24'd0);
    write_reg(CFG_CAPACITY, 24'd1000);
    write_reg(CFG_CAPBITS, 24'd0);
    queue_packet(32'd0, 4'd0, 1'b1, 24'd0, 24'd0);          // rank raised to 1
    queue_packet(32'hFFFF_FFFF, 4'hF, 1'b1, 24'd0, 24'd10);  // deepest division
    queue_packet(32'd100, 4'd1, 1'b1, 24'd0, 24'd500);
    queue_packet(32'd300, 4'd0, 1'b1, 24'd0, 24'd999);
    queue_packet(32'd7, 4'd2, 1'b0, 24'd0, 24'd999);         // control packet
    queue_packet(32'd400, 4'd0, 1'b1, 24'd0, 24'd1000);      // full
    queue_packet(32'd1000, 4'd0, 1'b1, 24'd0, 24'd600);
    queue_packet(32'd50, 4'd0, 1'b1, 24'd0, 24'd900);
    drain();
    // shrink the window below its fill, then bit mode
    write_reg(CFG_WINDOW, 24'd2);
    write_reg(CFG_KFRAC, 24'd131071);
    write_reg(CFG_CAPBITS, 24'd1);
    queue_packet(32'd2000, 4'd0, 1'b1, 24'd400, 24'd599);
    queue_packet(32'd2000, 4'd0, 1'b1, 24'd400, 24'd600);    // full in bit mode
    queue_packet(32'd9, 4'd0, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF);
    queue_packet(32'd3000, 4'd0, 1'b1, 24'd0, 24'd990);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph % 3) != 1;
      write_reg(CFG_DEFLECT, 24'($urandom_range(0, 4) != 0));
      write_reg(CFG_DIVISOR, pick(24'd0, 24'd1, 24'd255, 24'($urandom_range(2, 16))));
      write_reg(CFG_WINDOW, pick(24'd0, 24'd64, 24'd127, 24'($urandom_range(1, 65))));
      write_reg(CFG_PERIOD, pick(24'd0, 24'd1, 24'd1023, 24'($urandom_range(2, 6))));
      write_reg(CFG_KFRAC, pick(24'd0, 24'd65536, 24'd131071,
                                24'($urandom_range(0, 65536))));
      write_reg(CFG_CAPACITY, pick(24'd1, 24'hFF_FFFF, 24'd200,
                                   24'($urandom_range(1, 24'hFF_FFFF))));
      write_reg(CFG_CAPBITS, 24'($urandom_range(0, 1)));
      for (int n = 0; n < 85; n++) begin
        // ranks from a small pool collide with the window; fill mostly up to capacity
        s = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 40);
        f = 24'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                            : $urandom_range(0, m_capacity));
        queue_packet(s, 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 3)),
                     1'($urandom_range(0, 7) != 0),
                     24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                     : $urandom_range(0, m_capacity / 8)),
                     f);
      end
      drain();
    end

    repeat (600) @(posedge clk);
    if (n_errors == 0 && expected_decisions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
